### rtl/core/ssmf_pkg.sv
// Shared constants and types of the stereo sliding median filter.
package ssmf_pkg;

    localparam int MAX_SIDE_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 4;
    localparam int SIZE_BITS       = 8;
    localparam int ADDR_BITS       = 3;

    localparam logic REG_BEFORE = 1'b0;
    localparam logic REG_AFTER  = 1'b1;

    typedef struct packed {
        logic push;
        logic load_cnt;
        logic count;
        logic load_pick;
        logic rotate;
    } t_cell_ctrl;

endpackage

### rtl/core/ssmf_cell.sv
// One history cell: stored sample pair, circulating probe pair and rank counters.
module ssmf_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_BITS    = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ssmf_pkg::t_cell_ctrl   i_ctrl,
    input  logic                   i_win,
    input  logic [CNT_BITS-1:0]    i_k,
    input  logic [SAMPLE_BITS-1:0] i_prev_hl,
    input  logic [SAMPLE_BITS-1:0] i_prev_hr,
    input  logic [SAMPLE_BITS-1:0] i_next_pl,
    input  logic [SAMPLE_BITS-1:0] i_next_pr,
    input  logic                   i_next_tl,
    input  logic                   i_next_tr,
    output logic [SAMPLE_BITS-1:0] o_hl,
    output logic [SAMPLE_BITS-1:0] o_hr,
    output logic [SAMPLE_BITS-1:0] o_pl,
    output logic [SAMPLE_BITS-1:0] o_pr,
    output logic                   o_tl,
    output logic                   o_tr
);
    import ssmf_pkg::*;

    logic [SAMPLE_BITS-1:0] r_hl, r_hr, r_pl, r_pr;
    logic                   r_win, r_tl, r_tr;
    logic [CNT_BITS-1:0]    r_ltl, r_lel, r_ltr, r_ler;
    logic                   w_ml, w_mr;
    logic                   w_inc_ltl, w_inc_lel, w_inc_ltr, w_inc_ler;

    assign w_inc_ltl = r_tl && ($signed(r_pl) <  $signed(r_hl));
    assign w_inc_lel = r_tl && ($signed(r_pl) <= $signed(r_hl));
    assign w_inc_ltr = r_tr && ($signed(r_pr) <  $signed(r_hr));
    assign w_inc_ler = r_tr && ($signed(r_pr) <= $signed(r_hr));

    assign w_ml = r_win && (r_ltl <= i_k) && (i_k < r_lel);
    assign w_mr = r_win && (r_ltr <= i_k) && (i_k < r_ler);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hl  <= '0;
            r_hr  <= '0;
            r_win <= 1'b0;
            r_tl  <= 1'b0;
            r_tr  <= 1'b0;
            r_ltl <= '0;
            r_lel <= '0;
            r_ltr <= '0;
            r_ler <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_hl <= i_prev_hl;
                r_hr <= i_prev_hr;
            end
            if (i_ctrl.load_cnt) begin
                r_win <= i_win;
                r_pl  <= r_hl;
                r_pr  <= r_hr;
                r_tl  <= i_win;
                r_tr  <= i_win;
                r_ltl <= '0;
                r_lel <= '0;
                r_ltr <= '0;
                r_ler <= '0;
            end
            if (i_ctrl.count) begin
                r_ltl <= r_ltl + CNT_BITS'(w_inc_ltl);
                r_lel <= r_lel + CNT_BITS'(w_inc_lel);
                r_ltr <= r_ltr + CNT_BITS'(w_inc_ltr);
                r_ler <= r_ler + CNT_BITS'(w_inc_ler);
            end
            if (i_ctrl.load_pick) begin
                r_pl <= r_hl;
                r_pr <= r_hr;
                r_tl <= w_ml;
                r_tr <= w_mr;
            end
            if (i_ctrl.count || i_ctrl.rotate) begin
                r_pl <= i_next_pl;
                r_pr <= i_next_pr;
                r_tl <= i_next_tl;
                r_tr <= i_next_tr;
            end
        end
    end

    assign o_hl = r_hl;
    assign o_hr = r_hr;
    assign o_pl = r_pl;
    assign o_pr = r_pr;
    assign o_tl = r_tl;
    assign o_tr = r_tr;

endmodule

### rtl/core/stereo_sliding_median_filter_unit.sv
// Top level of the stereo sliding median filter: cell ring, sequencer, APB and output.
//
// Input beats arrive on s_axis (tdata: left sample low, right sample high) and
// one result beat leaves on m_axis per input beat (left median low, right
// median high). The result for a beat is the median of each channel's window
// of before_count older samples, the center sample and after_count newer
// samples, so the center lags the stream by after_count beats.
// Registers sit on the APB port: before_count at 0x0, after_count at 0x4,
// both 4 bits, values above MAX_SIDE saturate. Write them only while idle.
// Each beat steps through LOAD, COUNT, SEL, PICK and DONE: the probe
// ring circulates once past every cell to rank the samples and once more to
// bring a median-ranked sample to cell 0. The result waits in an output
// register; the next beat is taken meanwhile, and a held result only stalls
// the following beat in DONE, after its search, until the output is free.
// Reset clears the history to zero and both counts to one.
module stereo_sliding_median_filter_unit #(
    parameter int MAX_SIDE    = ssmf_pkg::MAX_SIDE_DEF,
    parameter int SAMPLE_BITS = ssmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // left_in, right_in
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // left_median, right_median
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ssmf_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import ssmf_pkg::*;

    localparam int DEPTH     = 2*MAX_SIDE + 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int STEP_BITS = $clog2(DEPTH);
    localparam int TD_BITS   = ((2*SAMPLE_BITS+7)/8)*8;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_COUNT = 6'b000100,
        ST_SEL   = 6'b001000,
        ST_PICK  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [STEP_BITS-1:0]   r_step, n_step;
    logic [CFG_BITS-1:0]    r_before, r_after;
    logic [SAMPLE_BITS-1:0] r_lmed, r_rmed;
    logic                   r_ovalid;
    logic [TD_BITS-1:0]     r_odata;

    t_cell_ctrl             w_ctrl;
    logic                   w_accept, w_last, w_cfg_wr, w_out_free;
    logic [SIZE_BITS-1:0]   w_bc, w_ac, w_bs, w_as, w_n;
    logic [CNT_BITS-1:0]    w_k;

    logic [SAMPLE_BITS-1:0] w_hl [DEPTH];
    logic [SAMPLE_BITS-1:0] w_hr [DEPTH];
    logic [SAMPLE_BITS-1:0] w_pl [DEPTH];
    logic [SAMPLE_BITS-1:0] w_pr [DEPTH];
    logic                   w_tl [DEPTH];
    logic                   w_tr [DEPTH];

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_before <= CFG_BITS'(1);
            r_after  <= CFG_BITS'(1);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_BEFORE: r_before <= pwdata[CFG_BITS-1:0];
                REG_AFTER:  r_after  <= pwdata[CFG_BITS-1:0];
                default:    r_before <= r_before;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BEFORE: prdata = 32'(r_before);
            REG_AFTER:  prdata = 32'(r_after);
            default:    prdata = '0;
        endcase
    end

    assign w_bc = SIZE_BITS'(r_before);
    assign w_ac = SIZE_BITS'(r_after);
    assign w_bs = (w_bc > SIZE_BITS'(MAX_SIDE)) ? SIZE_BITS'(MAX_SIDE) : w_bc;
    assign w_as = (w_ac > SIZE_BITS'(MAX_SIDE)) ? SIZE_BITS'(MAX_SIDE) : w_ac;
    assign w_n  = w_bs + w_as + SIZE_BITS'(1);
    assign w_k  = CNT_BITS'(w_n >> 1);

    // sequencer
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_last        = (r_step == STEP_BITS'(DEPTH - 1));
    assign w_out_free    = !r_ovalid || m_axis_tready;

    assign w_ctrl.push      = w_accept;
    assign w_ctrl.load_cnt  = (r_state == ST_LOAD);
    assign w_ctrl.count     = (r_state == ST_COUNT);
    assign w_ctrl.load_pick = (r_state == ST_SEL);
    assign w_ctrl.rotate    = (r_state == ST_PICK);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_COUNT;
                n_step  = '0;
            end
            ST_COUNT: begin
                n_step = r_step + STEP_BITS'(1);
                if (w_last) begin
                    n_state = ST_SEL;
                    n_step  = '0;
                end
            end
            ST_SEL: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                n_step = r_step + STEP_BITS'(1);
                if (w_last) begin
                    n_state = ST_DONE;
                    n_step  = '0;
                end
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // capture the median-ranked probe as it passes cell 0
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PICK) begin
            if (w_tl[0]) r_lmed <= w_pl[0];
            if (w_tr[0]) r_rmed <= w_pr[0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_odata <= TD_BITS'({r_rmed, r_lmed});
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // cell ring
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [SAMPLE_BITS-1:0] w_prev_l, w_prev_r;
        logic                   w_win;
        localparam int NXT = (i == DEPTH - 1) ? 0 : i + 1;

        if (i == 0) begin : g_head
            assign w_prev_l = s_axis_tdata[SAMPLE_BITS-1:0];
            assign w_prev_r = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end else begin : g_body
            assign w_prev_l = w_hl[i-1];
            assign w_prev_r = w_hr[i-1];
        end

        assign w_win = (SIZE_BITS'(i) < w_n);

        ssmf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CNT_BITS    (CNT_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_win     (w_win),
            .i_k       (w_k),
            .i_prev_hl (w_prev_l),
            .i_prev_hr (w_prev_r),
            .i_next_pl (w_pl[NXT]),
            .i_next_pr (w_pr[NXT]),
            .i_next_tl (w_tl[NXT]),
            .i_next_tr (w_tr[NXT]),
            .o_hl      (w_hl[i]),
            .o_hr      (w_hr[i]),
            .o_pl      (w_pl[i]),
            .o_pr      (w_pr[i]),
            .o_tl      (w_tl[i]),
            .o_tr      (w_tr[i])
        );
    end

endmodule
